// File: hw/rtl/itp_pkg.sv
// itp_pkg: shared types, character codes and helpers for the infix to postfix converter
// no dependencies; imported by itp_cell, itp_stack and infix_to_postfix_converter
`timescale 1ns / 1ps

package itp_pkg;

    localparam int CHAR_W = 8;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [1:0]        t_prec;
    typedef logic [1:0]        t_err;

    // character codes
    localparam t_char C_UPPER_A = 8'd65;
    localparam t_char C_UPPER_Z = 8'd90;
    localparam t_char C_LPAREN  = 8'h28;
    localparam t_char C_RPAREN  = 8'h29;
    localparam t_char C_PLUS    = 8'h2B;
    localparam t_char C_MINUS   = 8'h2D;
    localparam t_char C_STAR    = 8'h2A;
    localparam t_char C_SLASH   = 8'h2F;
    localparam t_char C_CARET   = 8'h5E;

    // error codes reported on the final transfer of an expression
    localparam t_err ERR_NONE      = 2'd0;
    localparam t_err ERR_OVERFLOW  = 2'd1;
    localparam t_err ERR_UNMATCHED = 2'd2;

    // command from the controller to the operator stack
    typedef struct packed {
        logic  push;
        logic  pop;
        logic  clear;
        t_char data;
    } t_stack_cmd;

    // status from the operator stack back to the controller
    typedef struct packed {
        logic  empty;
        logic  full;
        t_char top;
    } t_stack_stat;

    // operator precedence, zero for anything that is not an operator
    function automatic t_prec prec_of(input t_char c);
        t_prec p;
        case (c)
            C_PLUS, C_MINUS: p = 2'd1;
            C_STAR, C_SLASH: p = 2'd2;
            C_CARET:         p = 2'd3;
            default:         p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic logic is_letter(input t_char c);
        return (c >= C_UPPER_A) && (c <= C_UPPER_Z);
    endfunction

endpackage

// File: hw/rtl/itp_cell.sv
// itp_cell: one entry of the shifting operator stack
// depends on itp_pkg; instantiated in a chain by itp_stack
`timescale 1ns / 1ps

module itp_cell
    import itp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_push,
    input  logic  i_pop,
    input  t_char i_from_up,
    input  t_char i_from_down,
    output t_char o_data
);

    t_char r_data;

    // push takes the entry above, pop takes the entry below
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data <= i_from_up;
        end else if (i_pop) begin
            r_data <= i_from_down;
        end
    end

    assign o_data = r_data;

endmodule

// File: hw/rtl/itp_stack.sv
// itp_stack: operator stack built as a chain of itp_cell entries, top of stack in cell 0
// depends on itp_pkg and itp_cell
`timescale 1ns / 1ps

module itp_stack
    import itp_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_stack_cmd  i_cmd,
    output t_stack_stat o_stat
);

    localparam int CW = $clog2(DEPTH + 1);

    t_char          w_data [DEPTH];
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;

    // chain of cells, each shifting toward its neighbor on push or pop
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_char w_up;
        t_char w_down;
        if (g == 0) begin : g_first
            assign w_up = i_cmd.data;
        end else begin : g_mid_up
            assign w_up = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_down = w_data[g];
        end else begin : g_mid_down
            assign w_down = w_data[g+1];
        end
        itp_cell u_cell (
            .i_clk       (i_clk),
            .i_push      (i_cmd.push),
            .i_pop       (i_cmd.pop),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .o_data      (w_data[g])
        );
    end

    // fill count
    always_comb begin
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.push) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.top   = w_data[0];

`ifndef NO_ASSERTIONS
    // no pop from an empty stack
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> !o_stat.empty)
        else $error("pop on empty operator stack");

    // no push onto a full stack
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> !o_stat.full)
        else $error("push on full operator stack");
`endif

endmodule

// File: hw/rtl/infix_to_postfix_converter.sv
// infix_to_postfix_converter: top level, character controller, result hold stage and output register
// depends on itp_pkg and itp_stack
`timescale 1ns / 1ps

// Converts an infix expression, one ASCII character per input transfer, into
// postfix characters on the output. Letters A-Z pass through, operators are
// reordered by precedence through an operator stack of STACK_DEPTH entries,
// and the character marked end_of_expression flushes the stack; its final
// output transfer carries expression_done and the first error seen (stack
// overflow or unmatched close paren). Once a character is taken, no new one
// is accepted until the controller has gone through its scan step, which
// pops and emits operators as needed, then its finish step; an end-marked
// character also flushes the stack in between. The stack is a chain of cells
// that shifts one entry per cycle, which sets the pop rate when not stalled.
// Outputs leave through a registered stage; while that stage is full and
// i_out_ready is low, the controller waits on steps with a result to pass on.

module infix_to_postfix_converter
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_char,
    input  logic       i_end_of_expression,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_char,
    output logic       o_has_char,
    output logic       o_last_of_run,
    output logic       o_expression_done,
    output logic [1:0] o_error_code
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]  r_state;
    logic [1:0]  n_state;
    t_char       r_char;
    logic        r_end;
    t_err        r_err;
    logic        r_hold_v;
    t_char       r_hold_char;

    logic        r_out_valid;
    t_char       r_out_char;
    logic        r_out_has;
    logic        r_out_last;
    logic        r_out_done;
    t_err        r_out_err;

    t_stack_cmd  w_cmd;
    t_stack_stat w_stat;
    logic        w_gen;
    t_char       w_gen_char;
    logic        w_fin;
    t_err        w_err_set;
    logic        w_can_load;
    logic        w_blocked;
    logic        w_in_xfer;
    logic [1:0]  w_after;

    assign w_can_load = !r_out_valid || i_out_ready;
    assign w_blocked  = r_hold_v && !w_can_load;
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_after    = r_end ? S_FLUSH : S_FIN;
    assign o_in_ready = (r_state == S_IDLE);

    // operator stack
    itp_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

    // per-character control
    always_comb begin
        n_state    = r_state;
        w_cmd      = '0;
        w_gen      = 1'b0;
        w_gen_char = w_stat.top;
        w_fin      = 1'b0;
        w_err_set  = ERR_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (is_letter(r_char)) begin
                    if (!w_blocked) begin
                        w_gen      = 1'b1;
                        w_gen_char = r_char;
                        n_state    = w_after;
                    end
                end else if (r_char == C_LPAREN) begin
                    if (w_stat.full) begin
                        w_err_set = ERR_OVERFLOW;
                    end else begin
                        w_cmd.push = 1'b1;
                        w_cmd.data = r_char;
                    end
                    n_state = w_after;
                end else if (r_char == C_RPAREN) begin
                    if (w_stat.empty) begin
                        w_err_set = ERR_UNMATCHED;
                        n_state   = w_after;
                    end else if (w_stat.top == C_LPAREN) begin
                        w_cmd.pop = 1'b1;
                        n_state   = w_after;
                    end else if (!w_blocked) begin
                        w_cmd.pop = 1'b1;
                        w_gen     = 1'b1;
                    end
                end else if (prec_of(r_char) != 2'd0) begin
                    if (!w_stat.empty && (prec_of(w_stat.top) >= prec_of(r_char))) begin
                        if (!w_blocked) begin
                            w_cmd.pop = 1'b1;
                            w_gen     = 1'b1;
                        end
                    end else begin
                        if (w_stat.full) begin
                            w_err_set = ERR_OVERFLOW;
                        end else begin
                            w_cmd.push = 1'b1;
                            w_cmd.data = r_char;
                        end
                        n_state = w_after;
                    end
                end else begin
                    n_state = w_after;
                end
            end
            S_FLUSH: begin
                if (w_stat.empty) begin
                    n_state = S_FIN;
                end else if (w_stat.top == C_LPAREN) begin
                    w_cmd.pop = 1'b1;
                end else if (!w_blocked) begin
                    w_cmd.pop = 1'b1;
                    w_gen     = 1'b1;
                end
            end
            S_FIN: begin
                if (!(r_end || r_hold_v) || w_can_load) begin
                    w_fin       = 1'b1;
                    w_cmd.clear = r_end;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_err    <= ERR_NONE;
            r_hold_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fin && r_end) begin
                r_err <= ERR_NONE;
            end else if ((w_err_set != ERR_NONE) && (r_err == ERR_NONE)) begin
                r_err <= w_err_set;
            end
            if (w_gen) begin
                r_hold_v <= 1'b1;
            end else if (w_fin) begin
                r_hold_v <= 1'b0;
            end
        end
    end

    // captured input character and held result
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_char <= i_in_char;
            r_end  <= i_end_of_expression;
        end
        if (w_gen) begin
            r_hold_char <= w_gen_char;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_gen && r_hold_v) || (w_fin && (r_end || r_hold_v))) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_gen && r_hold_v) begin
            r_out_char <= r_hold_char;
            r_out_has  <= 1'b1;
            r_out_last <= 1'b0;
            r_out_done <= 1'b0;
            r_out_err  <= ERR_NONE;
        end else if (w_fin && (r_end || r_hold_v)) begin
            r_out_char <= r_hold_v ? r_hold_char : '0;
            r_out_has  <= r_hold_v;
            r_out_last <= 1'b1;
            r_out_done <= r_end;
            r_out_err  <= r_end ? r_err : ERR_NONE;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_char        = r_out_char;
    assign o_has_char        = r_out_has;
    assign o_last_of_run     = r_out_last;
    assign o_expression_done = r_out_done;
    assign o_error_code      = r_out_err;

`ifndef NO_ASSERTIONS
    // an accepted character always moves the controller into its scan step
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_SCAN))
        else $error("accepted character did not start a scan");

    // the final transfer of an expression also ends its run
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> r_out_last)
        else $error("expression done without last of run");

    // an error code only appears on the final transfer
    a_err_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_err != ERR_NONE)) |-> r_out_done)
        else $error("error code outside the final transfer");
`endif

endmodule
